/* rtl/mnc_pkg.sv */
`default_nettype none

package mnc_pkg;

	// Field widths and limits
	localparam int MAX_LEVEL      = 10;
	localparam int AXIS_W         = MAX_LEVEL;
	localparam int CODE_W         = 30;
	localparam int IDX_W          = 5;
	localparam int LVL_W          = 4;
	localparam int COORD_W        = AXIS_W + 2;
	localparam int NEIGHBOR_COUNT = 26;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBOR_COUNT - 1);
	localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(MAX_LEVEL);

	// Per-axis step: +1, 0 or -1
	typedef logic signed [1:0] step_t;

	localparam step_t STEP_P = 2'sb01;
	localparam step_t STEP_0 = 2'sb00;
	localparam step_t STEP_M = 2'sb11;

	typedef struct packed {
		step_t dx;
		step_t dy;
		step_t dz;
	} offset_t;

	// One neighbour request from the sequencer to the pipeline
	typedef struct packed {
		logic              valid;
		logic [AXIS_W-1:0] x;
		logic [AXIS_W-1:0] y;
		logic [AXIS_W-1:0] z;
		logic [IDX_W-1:0]  idx;
		logic [LVL_W-1:0]  lvl;
	} issue_t;

	// Neighbour offsets in emission order
	function automatic offset_t neighbor_offset(input logic [IDX_W-1:0] idx);
		offset_t o;
		o = '{STEP_0, STEP_0, STEP_0};
		case (idx)
			5'd0:  o = '{STEP_P, STEP_0, STEP_0};
			5'd1:  o = '{STEP_M, STEP_0, STEP_0};
			5'd2:  o = '{STEP_0, STEP_P, STEP_0};
			5'd3:  o = '{STEP_0, STEP_M, STEP_0};
			5'd4:  o = '{STEP_0, STEP_0, STEP_P};
			5'd5:  o = '{STEP_0, STEP_0, STEP_M};
			5'd6:  o = '{STEP_P, STEP_P, STEP_P};
			5'd7:  o = '{STEP_M, STEP_M, STEP_P};
			5'd8:  o = '{STEP_P, STEP_M, STEP_P};
			5'd9:  o = '{STEP_M, STEP_P, STEP_P};
			5'd10: o = '{STEP_P, STEP_0, STEP_P};
			5'd11: o = '{STEP_M, STEP_0, STEP_P};
			5'd12: o = '{STEP_0, STEP_P, STEP_P};
			5'd13: o = '{STEP_0, STEP_M, STEP_P};
			5'd14: o = '{STEP_P, STEP_P, STEP_0};
			5'd15: o = '{STEP_P, STEP_M, STEP_0};
			5'd16: o = '{STEP_M, STEP_P, STEP_0};
			5'd17: o = '{STEP_M, STEP_M, STEP_0};
			5'd18: o = '{STEP_P, STEP_P, STEP_M};
			5'd19: o = '{STEP_P, STEP_M, STEP_M};
			5'd20: o = '{STEP_0, STEP_P, STEP_M};
			5'd21: o = '{STEP_0, STEP_M, STEP_M};
			5'd22: o = '{STEP_M, STEP_P, STEP_M};
			5'd23: o = '{STEP_M, STEP_M, STEP_M};
			5'd24: o = '{STEP_P, STEP_0, STEP_M};
			5'd25: o = '{STEP_M, STEP_0, STEP_M};
			default: o = '{STEP_0, STEP_0, STEP_0};
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

/* rtl/mnc_seq.sv */
`default_nettype none

module mnc_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [mnc_pkg::CODE_W-1:0] center_code,
	input  wire logic [mnc_pkg::LVL_W-1:0]  level,
	input  wire logic                      advance,
	output mnc_pkg::issue_t                issue
);
	import mnc_pkg::*;

	logic              busy_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [AXIS_W-1:0] x_q, y_q, z_q;
	logic [LVL_W-1:0]  lvl_q;

	logic              accept;
	logic              issue_last;
	logic [AXIS_W-1:0] dx, dy, dz;

	// De-interleave the centre code, x on the top bit of each triple
	always_comb begin
		for (int i = 0; i < AXIS_W; i++) begin
			if (LVL_W'(i) < level) begin
				dx[i] = center_code[3*i+2];
				dy[i] = center_code[3*i+1];
				dz[i] = center_code[3*i];
			end else begin
				dx[i] = 1'b0;
				dy[i] = 1'b0;
				dz[i] = 1'b0;
			end
		end
	end

	assign issue_last = busy_q && advance && (cnt_q == LAST_IDX);
	assign in_ready   = !busy_q || issue_last;
	assign accept     = in_valid && in_ready;

	// Request counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && advance) begin
			if (cnt_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	// Centre held for all 26 neighbours
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= dx;
			y_q   <= dy;
			z_q   <= dz;
			lvl_q <= level;
		end
	end

	assign issue.valid = busy_q;
	assign issue.x     = x_q;
	assign issue.y     = y_q;
	assign issue.z     = z_q;
	assign issue.idx   = cnt_q;
	assign issue.lvl   = lvl_q;

endmodule

`default_nettype wire

/* rtl/mnc_pipe.sv */
`default_nettype none

module mnc_pipe (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mnc_pkg::issue_t            issue,
	output logic                            advance,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [mnc_pkg::CODE_W-1:0]      neighbor_code,
	output logic [mnc_pkg::IDX_W-1:0]       neighbor_index,
	output logic                            in_bounds,
	output logic                            last
);
	import mnc_pkg::*;

	// Stage 1: centre and decoded offset
	logic              v_s1;
	logic [AXIS_W-1:0] x_s1, y_s1, z_s1;
	offset_t           off_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [LVL_W-1:0]  lvl_s1;

	// Stage 2: neighbour coordinates and bounds
	logic              v_s2;
	logic [AXIS_W-1:0] x_s2, y_s2, z_s2;
	logic              ok_s2;
	logic [IDX_W-1:0]  idx_s2;

	// Stage 3: output register
	logic              v_s3;
	logic [CODE_W-1:0] code_s3;
	logic              ok_s3;
	logic [IDX_W-1:0]  idx_s3;

	logic [COORD_W-1:0] nx, ny, nz, side;
	logic               ok;
	logic [CODE_W-1:0]  code;

	// Whole pipe moves together unless the output is held
	assign advance = !v_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1   <= issue.x;
			y_s1   <= issue.y;
			z_s1   <= issue.z;
			off_s1 <= neighbor_offset(issue.idx);
			idx_s1 <= issue.idx;
			lvl_s1 <= issue.lvl;
		end
	end

	// Add the step on each axis and check against the grid side
	always_comb begin
		side = COORD_W'(1) << lvl_s1;
		nx = {2'b00, x_s1} + {{(COORD_W-2){off_s1.dx[1]}}, off_s1.dx};
		ny = {2'b00, y_s1} + {{(COORD_W-2){off_s1.dy[1]}}, off_s1.dy};
		nz = {2'b00, z_s1} + {{(COORD_W-2){off_s1.dz[1]}}, off_s1.dz};
		ok = !nx[COORD_W-1] && (nx < side) &&
		     !ny[COORD_W-1] && (ny < side) &&
		     !nz[COORD_W-1] && (nz < side);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s2   <= nx[AXIS_W-1:0];
			y_s2   <= ny[AXIS_W-1:0];
			z_s2   <= nz[AXIS_W-1:0];
			ok_s2  <= ok;
			idx_s2 <= idx_s1;
		end
	end

	// Re-interleave; in-bounds coordinates have no bits above the level
	always_comb begin
		for (int i = 0; i < AXIS_W; i++) begin
			code[3*i+2] = x_s2[i];
			code[3*i+1] = y_s2[i];
			code[3*i]   = z_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_s3 <= ok_s2 ? code : '0;
			ok_s3   <= ok_s2;
			idx_s3  <= idx_s2;
		end
	end

	assign out_valid      = v_s3;
	assign neighbor_code  = code_s3;
	assign neighbor_index = idx_s3;
	assign in_bounds      = ok_s3;
	assign last           = (idx_s3 == LAST_IDX);

endmodule

`default_nettype wire

/* rtl/morton_neighbor_codes_3d_unit.sv */
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | center_code[29:0]
// cfg      | cfg_valid / cfg_ready | grid_level[3:0]
// out      | out_valid / out_ready | neighbor_code, neighbor_index, in_bounds, last
//
// Each centre request gives 26 results, one per cycle from the neighbour
// sequencer while the output is not stalled; a new request is taken on the
// cycle its predecessor's last neighbour is issued. Results pass through
// three register stages after issue. Reset clears the valid bits and counter
// and sets grid_level to 10. Output stall holds every stage.

module morton_neighbor_codes_3d_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [mnc_pkg::CODE_W-1:0] center_code,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [mnc_pkg::LVL_W-1:0]  grid_level,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [mnc_pkg::CODE_W-1:0]      neighbor_code,
	output logic [mnc_pkg::IDX_W-1:0]       neighbor_index,
	output logic                            in_bounds,
	output logic                            last
);
	import mnc_pkg::*;

	logic [LVL_W-1:0] grid_level_q;
	logic [LVL_W-1:0] level_eff;
	logic             advance;
	issue_t           issue;

	assign cfg_ready = 1'b1;

	// Level register, saturated on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_level_q <= LVL_MAX;
		end else if (cfg_valid) begin
			grid_level_q <= grid_level;
		end
	end

	assign level_eff = (grid_level_q > LVL_MAX) ? LVL_MAX : grid_level_q;

	mnc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.center_code (center_code),
		.level       (level_eff),
		.advance     (advance),
		.issue       (issue)
	);

	mnc_pipe u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.issue          (issue),
		.advance        (advance),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.neighbor_code  (neighbor_code),
		.neighbor_index (neighbor_index),
		.in_bounds      (in_bounds),
		.last           (last)
	);

endmodule

`default_nettype wire

/* tb/mnc_neighbour_checker.sv */
`timescale 1ns / 100ps

// Watches the centre, level and neighbour channels of the neighbour code unit,
// predicts the 26 neighbour results of every accepted centre request and
// compares each accepted result, in order, with the oldest prediction.
module mnc_neighbour_checker
	import mnc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [CODE_W-1:0] center_code,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [LVL_W-1:0]  grid_level,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [CODE_W-1:0] neighbor_code,
	input  wire logic [IDX_W-1:0]  neighbor_index,
	input  wire logic              in_bounds,
	input  wire logic              last,
	output int                     mismatches,
	output int                     outstanding,
	output int                     checked
);

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [IDX_W-1:0]  idx;
		logic              ok;
		logic              last_flag;
	} neighbour_t;

	logic [LVL_W-1:0] level_copy;
	neighbour_t       pending_neighbours [$];

	// Step per axis for each neighbour, in emission order
	function automatic void offset_of(input int k, output int dx, output int dy, output int dz);
		dx = 0;
		dy = 0;
		dz = 0;
		case (k)
			0:  begin dx =  1; dy =  0; dz =  0; end
			1:  begin dx = -1; dy =  0; dz =  0; end
			2:  begin dx =  0; dy =  1; dz =  0; end
			3:  begin dx =  0; dy = -1; dz =  0; end
			4:  begin dx =  0; dy =  0; dz =  1; end
			5:  begin dx =  0; dy =  0; dz = -1; end
			6:  begin dx =  1; dy =  1; dz =  1; end
			7:  begin dx = -1; dy = -1; dz =  1; end
			8:  begin dx =  1; dy = -1; dz =  1; end
			9:  begin dx = -1; dy =  1; dz =  1; end
			10: begin dx =  1; dy =  0; dz =  1; end
			11: begin dx = -1; dy =  0; dz =  1; end
			12: begin dx =  0; dy =  1; dz =  1; end
			13: begin dx =  0; dy = -1; dz =  1; end
			14: begin dx =  1; dy =  1; dz =  0; end
			15: begin dx =  1; dy = -1; dz =  0; end
			16: begin dx = -1; dy =  1; dz =  0; end
			17: begin dx = -1; dy = -1; dz =  0; end
			18: begin dx =  1; dy =  1; dz = -1; end
			19: begin dx =  1; dy = -1; dz = -1; end
			20: begin dx =  0; dy =  1; dz = -1; end
			21: begin dx =  0; dy = -1; dz = -1; end
			22: begin dx = -1; dy =  1; dz = -1; end
			23: begin dx = -1; dy = -1; dz = -1; end
			24: begin dx =  1; dy =  0; dz = -1; end
			25: begin dx = -1; dy =  0; dz = -1; end
			default: begin dx = 0; dy = 0; dz = 0; end
		endcase
	endfunction

	// Neighbour k of a centre code at a given level register value
	function automatic neighbour_t predict_neighbour(input logic [CODE_W-1:0] code,
			input logic [LVL_W-1:0] lvl_reg, input int k);
		neighbour_t r;
		int lv, side, cx, cy, cz, dx, dy, dz, nx, ny, nz;
		// levels above the maximum saturate
		lv = (int'(lvl_reg) > MAX_LEVEL) ? MAX_LEVEL : int'(lvl_reg);
		side = 1 << lv;
		cx = 0;
		cy = 0;
		cz = 0;
		for (int i = 0; i < lv; i++) begin
			cx |= int'(code[3*i+2]) << i;
			cy |= int'(code[3*i+1]) << i;
			cz |= int'(code[3*i])   << i;
		end
		offset_of(k, dx, dy, dz);
		nx = cx + dx;
		ny = cy + dy;
		nz = cz + dz;
		r.ok = nx >= 0 && nx < side && ny >= 0 && ny < side && nz >= 0 && nz < side;
		r.code = '0;
		if (r.ok) begin
			for (int i = 0; i < lv; i++) begin
				r.code[3*i+2] = nx[i];
				r.code[3*i+1] = ny[i];
				r.code[3*i]   = nz[i];
			end
		end
		r.idx = IDX_W'(k);
		r.last_flag = (k == NEIGHBOR_COUNT - 1);
		return r;
	endfunction

	// Level shadow, result compare, then predictions for a new centre
	always @(posedge clk or negedge arst_n) begin
		neighbour_t want;
		neighbour_t got;
		if (!arst_n) begin
			level_copy = LVL_MAX;
			pending_neighbours.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				level_copy = grid_level;

			if (out_valid && out_ready) begin
				got = '{neighbor_code, neighbor_index, in_bounds, last};
				if (pending_neighbours.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result code=%h index=%0d in_bounds=%b last=%b",
							$realtime, got.code, got.idx, got.ok, got.last_flag);
				end else begin
					want = pending_neighbours.pop_front();
					checked++;
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp code=%h index=%0d in_bounds=%b last=%b",
								" got code=%h index=%0d in_bounds=%b last=%b"}, $realtime,
								want.code, want.idx, want.ok, want.last_flag,
								got.code, got.idx, got.ok, got.last_flag);
					end
				end
			end

			if (in_valid && in_ready)
				for (int k = 0; k < NEIGHBOR_COUNT; k++)
					pending_neighbours.push_back(predict_neighbour(center_code, level_copy, k));

			outstanding <= pending_neighbours.size();
		end
	end

endmodule

/* tb/tb_morton_neighbor_codes_3d_unit.sv */
`timescale 1ns / 100ps

module tb_morton_neighbor_codes_3d_unit;
	import mnc_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	// three register stages plus margin
	localparam int SETTLE_CYCLES = 8;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CODE_W-1:0] center_code;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LVL_W-1:0]  grid_level;
	logic              out_valid;
	logic              out_ready;
	logic [CODE_W-1:0] neighbor_code;
	logic [IDX_W-1:0]  neighbor_index;
	logic              in_bounds;
	logic              last;

	int in_idle_pct;
	int out_stall_pct;
	int cycle_cnt;
	int centres_sent;
	int level_writes;
	int mismatches;
	int outstanding;
	int checked;

	morton_neighbor_codes_3d_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.center_code    (center_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.grid_level     (grid_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.neighbor_code  (neighbor_code),
		.neighbor_index (neighbor_index),
		.in_bounds      (in_bounds),
		.last           (last)
	);

	mnc_neighbour_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.center_code    (center_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.grid_level     (grid_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.neighbor_code  (neighbor_code),
		.neighbor_index (neighbor_index),
		.in_bounds      (in_bounds),
		.last           (last),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.checked        (checked)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Result side back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= out_stall_pct);

	// Run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_morton_neighbor_codes_3d_unit NOT OK");
		$finish;
	end

	// One centre request, with random idle cycles ahead of it
	task automatic send_centre(input logic [CODE_W-1:0] code);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			center_code <= CODE_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		center_code <= code;
		do @(posedge clk); while (!in_ready);
		centres_sent++;
	endtask

	// Hold off until every predicted neighbour has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Level register write, only once the unit has gone quiet
	task automatic write_level(input logic [LVL_W-1:0] lvl);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		grid_level <= lvl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		level_writes++;
	endtask

	initial begin
		logic [CODE_W-1:0] code;
		logic [LVL_W-1:0]  lvl;
		int                eff;
		int                maxc;
		int                coord [3];

		arst_n = 1'b0;
		in_valid = 1'b0;
		center_code = '0;
		cfg_valid = 1'b0;
		grid_level = '0;
		out_ready = 1'b0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		centres_sent = 0;
		level_writes = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset level: corners and a couple of arbitrary centres
		send_centre(30'h00000000);
		send_centre(30'h3FFFFFFF);
		send_centre(30'h15555555);
		send_centre(CODE_W'($urandom));

		// Two-cell grid: every corner, then junk above the used bits
		write_level(4'd1);
		for (int c = 0; c < 8; c++)
			send_centre(CODE_W'(c));
		send_centre(30'h3FFFFFFE);

		// Single-cell grid, nothing in bounds
		write_level(4'd0);
		send_centre(30'h3FFFFFFF);
		send_centre(30'h00000000);

		// Register above the maximum level saturates
		write_level(4'd15);
		send_centre(30'h3FFFFFFF);
		send_centre(30'h00000000);

		// Four-cell grid: fully interior centre, far corner, a mixed one
		write_level(4'd2);
		send_centre(30'h00000007);
		send_centre(30'h0000003F);
		send_centre(30'h2AAAAAA2);

		write_level(4'd11);
		send_centre(CODE_W'($urandom));

		// Random segments, cycling through the idle and stall mixes
		for (int seg = 0; seg < 10; seg++) begin
			case (seg % 4)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 56; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 56; end
				default: begin in_idle_pct = 12; out_stall_pct = 12; end
			endcase
			if ($urandom_range(4) == 0)
				lvl = LVL_W'($urandom);
			else
				lvl = LVL_W'($urandom_range(MAX_LEVEL, 1));
			write_level(lvl);
			eff = (int'(lvl) > MAX_LEVEL) ? MAX_LEVEL : int'(lvl);
			maxc = (1 << eff) - 1;

			for (int n = 0; n < 13; n++) begin
				code = CODE_W'($urandom);
				// mostly centres on faces and corners of the grid
				if ($urandom_range(3) != 0) begin
					for (int a = 0; a < 3; a++) begin
						case ($urandom_range(3))
							0: coord[a] = 0;
							1: coord[a] = maxc;
							default: coord[a] = $urandom_range(maxc);
						endcase
					end
					for (int i = 0; i < eff; i++) begin
						code[3*i+2] = coord[0][i];
						code[3*i+1] = coord[1][i];
						code[3*i]   = coord[2][i];
					end
				end
				if (seg == 5 && n % 5 == 0)
					drain();
				send_centre(code);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d centre codes over %0d level writes (0, 1, 2, 11, 15 and random),",
			centres_sent, level_writes);
		$display("with %0d neighbour results compared under varied idle and stall patterns.",
			checked);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_morton_neighbor_codes_3d_unit OK");
		else
			$display("tb_morton_neighbor_codes_3d_unit NOT OK");
		$finish;
	end

endmodule

/* files.f */
rtl/mnc_pkg.sv
rtl/mnc_seq.sv
rtl/mnc_pipe.sv
rtl/morton_neighbor_codes_3d_unit.sv
tb/mnc_neighbour_checker.sv
tb/tb_morton_neighbor_codes_3d_unit.sv
